// ===== sv/bimm_pkg.sv =====
// Shared types and constants for the batched integer matrix multiply block.
// No dependencies; imported by the engine, the top level and the checker.
`default_nettype none

package bimm_pkg;

   localparam int DATA_W      = 32;  // element and product width
   localparam int SIDE_W      = 5;   // row and column index width
   localparam int BATCH_W     = 2;   // batch index width
   localparam int DIM_W       = 6;   // dimension register width
   localparam int NB_W        = 3;   // batch count register width
   localparam int CSR_IDX_W   = 3;
   localparam int ADDR_FULL_W = BATCH_W + 2 * SIDE_W;
   localparam int MAX_SIDE    = 1 << SIDE_W;
   localparam int MAX_BATCH   = 1 << BATCH_W;

   // item commands
   localparam logic [1:0] CMD_WRITE_A = 2'd0;
   localparam logic [1:0] CMD_WRITE_B = 2'd1;
   localparam logic [1:0] CMD_COMPUTE = 2'd2;

   // share modes
   localparam logic [1:0] SHARE_NONE = 2'd0;
   localparam logic [1:0] SHARE_A    = 2'd1;
   localparam logic [1:0] SHARE_B    = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_M      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_K     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_N      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BATCH_COUNT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SHARE_MODE  = 3'd4;

   // effective (clamped) configuration
   typedef struct packed {
      logic [DIM_W-1:0] m;
      logic [DIM_W-1:0] k;
      logic [DIM_W-1:0] n;
      logic [NB_W-1:0]  nb;
      logic             a_shared;
      logic             b_shared;
   } cfg_type;

endpackage

`default_nettype wire

// ===== sv/batched_integer_matrix_multiply.sv =====
// Batched integer matrix multiply: an A and a B element store, each a
// synchronous RAM, and one multiply-accumulate unit that walks inner_k.
//
// req_*: one item per command. A write stores req_value at a batch, row and
//   column of A or B and gives no result unless an index is out of range.
//   A compute returns one element of the batched product on rsp_*.
// rsp_*: product and status (1 for an index outside the configured
//   dimensions or an unknown command, with product 0).
// csr_*: rows_m, inner_k, cols_n, batch_count, share_mode; write only while
//   the block is idle. Out-of-range values are clamped.
// Sequence: a write in range leaves the block idle, ready for the next item.
//   A compute holds off new items until its result is loaded: one store read
//   and one multiply-accumulate per inner step, then read, multiply and drain.
//   An error item also holds off new items until its result is loaded.
// The result sits in an output register; while the receiver stalls, writes
//   are still taken and a finished compute waits in its last state.
// Reset clears control and configuration; store content is undefined until
//   written, and reading an unwritten element gives an undefined product.
`default_nettype none

module batched_integer_matrix_multiply #(
   parameter int STORE_DEPTH = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_command,
   input  logic [bimm_pkg::BATCH_W-1:0]         req_batch_index,
   input  logic [bimm_pkg::SIDE_W-1:0]          req_row_index,
   input  logic [bimm_pkg::SIDE_W-1:0]          req_col_index,
   input  logic signed [bimm_pkg::DATA_W-1:0]   req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [bimm_pkg::DATA_W-1:0]   rsp_product,
   output logic                                 rsp_status,
   input  logic                                 csr_write_en,
   input  logic [bimm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bimm_pkg::DIM_W-1:0]           csr_wdata
);
   import bimm_pkg::*;

   logic [DIM_W-1:0] rows_m_ff, inner_k_ff, cols_n_ff;
   logic [NB_W-1:0]  batch_count_ff;
   logic [1:0]       share_mode_ff;
   cfg_type          cfg;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_m_ff      <= DIM_W'(1);
         inner_k_ff     <= DIM_W'(1);
         cols_n_ff      <= DIM_W'(1);
         batch_count_ff <= NB_W'(1);
         share_mode_ff  <= SHARE_NONE;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_ROWS_M:      rows_m_ff      <= csr_wdata;
            CSR_INNER_K:     inner_k_ff     <= csr_wdata;
            CSR_COLS_N:      cols_n_ff      <= csr_wdata;
            CSR_BATCH_COUNT: batch_count_ff <= csr_wdata[NB_W-1:0];
            CSR_SHARE_MODE:  share_mode_ff  <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // clamp zero up to one and large values down to the maximum
   always_comb begin
      cfg.m = (rows_m_ff == '0) ? DIM_W'(1)
            : (rows_m_ff > DIM_W'(MAX_SIDE)) ? DIM_W'(MAX_SIDE) : rows_m_ff;
      cfg.k = (inner_k_ff == '0) ? DIM_W'(1)
            : (inner_k_ff > DIM_W'(MAX_SIDE)) ? DIM_W'(MAX_SIDE) : inner_k_ff;
      cfg.n = (cols_n_ff == '0) ? DIM_W'(1)
            : (cols_n_ff > DIM_W'(MAX_SIDE)) ? DIM_W'(MAX_SIDE) : cols_n_ff;
      cfg.nb = (batch_count_ff == '0) ? NB_W'(1)
             : (batch_count_ff > NB_W'(MAX_BATCH)) ? NB_W'(MAX_BATCH) : batch_count_ff;
      cfg.a_shared = (share_mode_ff == SHARE_A);
      cfg.b_shared = (share_mode_ff == SHARE_B);
   end

   bimm_engine #(.STORE_DEPTH(STORE_DEPTH)) u_engine (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_batch_index (req_batch_index),
      .req_row_index   (req_row_index),
      .req_col_index   (req_col_index),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_product     (rsp_product),
      .rsp_status      (rsp_status)
   );

endmodule

`default_nettype wire

// ===== sv/bimm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module bimm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/bimm_engine.sv =====
// Command decode, A/B element stores and the multiply-accumulate sequencer.
// Depends on bimm_pkg and bimm_ram.
`default_nettype none

module bimm_engine #(
   parameter int STORE_DEPTH = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bimm_pkg::cfg_type                    cfg,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_command,
   input  logic [bimm_pkg::BATCH_W-1:0]         req_batch_index,
   input  logic [bimm_pkg::SIDE_W-1:0]          req_row_index,
   input  logic [bimm_pkg::SIDE_W-1:0]          req_col_index,
   input  logic signed [bimm_pkg::DATA_W-1:0]   req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [bimm_pkg::DATA_W-1:0]   rsp_product,
   output logic                                 rsp_status
);
   import bimm_pkg::*;

   localparam int AW = $clog2(STORE_DEPTH);

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_type;

   state_type              state_ff, state_in;
   logic [DIM_W-1:0]       k_ff;
   logic [SIDE_W-1:0]      row_ff, col_ff;
   logic [BATCH_W-1:0]     ba_ff, bb_ff;
   logic                   rd_vld_ff, prod_vld_ff;
   logic [DATA_W-1:0]      prod_ff, acc_ff;
   logic                   err_ff, err_in;
   logic                   rsp_valid_ff;
   logic [DATA_W-1:0]      rsp_product_ff;
   logic                   rsp_status_ff;

   logic                   accept, is_write, is_a, wr_shared, wr_ok, cmp_ok, in_store;
   logic [BATCH_W-1:0]     wr_batch;
   logic [DIM_W-1:0]       rlim, clim;
   logic [ADDR_FULL_W-1:0] wr_full, a_rd_full, b_rd_full;
   logic                   a_wr_en, b_wr_en;
   logic [DATA_W-1:0]      a_rd, b_rd;
   logic                   issue, drained, out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // decode of the incoming item
   always_comb begin
      is_write  = (req_command == CMD_WRITE_A) || (req_command == CMD_WRITE_B);
      is_a      = (req_command == CMD_WRITE_A);
      wr_shared = is_a ? cfg.a_shared : cfg.b_shared;
      wr_batch  = wr_shared ? '0 : req_batch_index;
      rlim      = is_a ? cfg.m : cfg.k;
      clim      = is_a ? cfg.k : cfg.n;
      wr_ok     = ({1'b0, req_row_index} < rlim) && ({1'b0, req_col_index} < clim)
                  && ({1'b0, wr_batch} < cfg.nb);
      cmp_ok    = ({1'b0, req_row_index} < cfg.m) && ({1'b0, req_col_index} < cfg.n)
                  && ({1'b0, req_batch_index} < cfg.nb);
      wr_full   = {wr_batch, req_row_index, req_col_index};
      in_store  = 32'(wr_full) < 32'(STORE_DEPTH);
      a_wr_en   = accept && (req_command == CMD_WRITE_A) && wr_ok && in_store;
      b_wr_en   = accept && (req_command == CMD_WRITE_B) && wr_ok && in_store;
   end

   // walk the inner dimension: A along its row, B down its column
   assign a_rd_full = {ba_ff, row_ff, k_ff[SIDE_W-1:0]};
   assign b_rd_full = {bb_ff, k_ff[SIDE_W-1:0], col_ff};
   assign issue     = (state_ff == ST_RUN) && (k_ff < cfg.k);
   assign drained   = (state_ff == ST_RUN) && !issue && !rd_vld_ff && !prod_vld_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   bimm_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_a_store (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (AW'(wr_full)),
      .wr_data (req_value),
      .rd_addr (AW'(a_rd_full)),
      .rd_data (a_rd)
   );

   bimm_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_b_store (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (AW'(wr_full)),
      .wr_data (req_value),
      .rd_addr (AW'(b_rd_full)),
      .rd_data (b_rd)
   );

   // A write lands before the next item can be taken, and a compute only
   // reads from the cycle after its acceptance, so no forwarding is needed.
   always_comb begin
      state_in = state_ff;
      err_in   = err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               err_in = !((req_command == CMD_COMPUTE) && cmp_ok);
               if ((req_command == CMD_COMPUTE) && cmp_ok) begin
                  state_in = ST_RUN;
               end else if (is_write && wr_ok) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_RUN: begin
            if (drained) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      err_ff <= err_in;
      if (accept) begin
         row_ff <= req_row_index;
         col_ff <= req_col_index;
         ba_ff  <= cfg.a_shared ? '0 : req_batch_index;
         bb_ff  <= cfg.b_shared ? '0 : req_batch_index;
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + prod_ff;
      end
      if (rd_vld_ff) begin
         prod_ff <= a_rd * b_rd;
      end
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_product_ff <= err_ff ? '0 : acc_ff;
         rsp_status_ff  <= err_ff;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_vld_ff   <= issue;
         prod_vld_ff <= rd_vld_ff;
         if (accept) begin
            k_ff <= '0;
         end else if (issue) begin
            k_ff <= k_ff + 1'b1;
         end
         // load a new result if it is ready, else drop the taken one
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_product = rsp_product_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

`default_nettype wire

// ===== sv/bimm_checker.sv =====
// Port-level checks for the batched integer matrix multiply, bound to the
// top level. Depends on bimm_pkg.
`default_nettype none

module bimm_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic [1:0]                           req_command,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [bimm_pkg::DATA_W-1:0]   rsp_product,
   input logic                                 rsp_status
);
   import bimm_pkg::*;

   // a stalled result stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_product) && $stable(rsp_status))
      else $error("stalled result changed");

   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_product == '0)
      else $error("error result with nonzero product");

   // a compute or unknown command always occupies the block for a while
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_command != CMD_WRITE_A)
      && (req_command != CMD_WRITE_B)
      |=> req_stall)
      else $error("block took an item right after a compute");

endmodule

bind batched_integer_matrix_multiply bimm_checker u_checker (.*);

`default_nettype wire
